// ----- rtl/cdbt_pkg.sv -----
// Shared types and constants for the Collatz descent checker.
package cdbt_pkg;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_STEP_LIMIT = 1'b1;

  localparam int unsigned THR_W   = 7;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [THR_W-1:0]   THR_RESET   = 7'd71;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd5000;

  // Result status codes
  localparam logic [1:0] STATUS_BELOW    = 2'd0;
  localparam logic [1:0] STATUS_LIMIT    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [63:0] start_high;
    logic [63:0] start_low;
  } in_payload_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [LIMIT_W-1:0] steps_taken;
  } out_payload_t;

  // Flags from the step unit to the sequencer
  typedef struct packed {
    logic below;
    logic odd;
    logic ovf;
  } step_flags_t;

endpackage

// ----- rtl/cdbt_step.sv -----
// Shared step unit: threshold test, overflow guard and one accelerated Collatz step.
module cdbt_step #(
  parameter int unsigned VALUE_WIDTH = 128
) (
  input  logic [VALUE_WIDTH-1:0]  x,
  input  logic [VALUE_WIDTH-1:0]  thr_mask,
  output logic [VALUE_WIDTH-1:0]  x_nxt,
  output cdbt_pkg::step_flags_t   flags
);

  // Overflow bound (2^W - 2) / 3, rounded down: an odd value above it is flagged as overflow
  localparam logic [VALUE_WIDTH-1:0] GUARD = ({VALUE_WIDTH{1'b1}} - 1) / 3;

  logic [VALUE_WIDTH-1:0] half;

  assign half = x >> 1;

  // Flags for the sequencer
  assign flags.below = ((x & thr_mask) == '0);
  assign flags.odd   = x[0];
  assign flags.ovf   = (x > GUARD);

  // Even: halve. Odd: x + x/2 + 1 equals (3x+1)/2.
  always_comb begin
    if (x[0]) begin
      x_nxt = x + half + VALUE_WIDTH'(1);
    end else begin
      x_nxt = half;
    end
  end

endmodule

// ----- rtl/collatz_descent_below_threshold.sv -----
// Top level of the accelerated Collatz descent checker.
// An accepted item is worked in the run state, one map step a cycle, and its result is then registered.
// Only one item is in work at a time; the single step unit sets the pace.
// The input stalls while an item is in work; a finished result waits in the output register.
// Reset (rst_n low, synchronous) clears the sequencer and output valid, and sets
// threshold_exponent to 71 and step_limit to 5000.
module collatz_descent_below_threshold #(
  parameter int unsigned VALUE_WIDTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cdbt_pkg::CFG_W-1:0]    cfg_wdata,
  // requests in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cdbt_pkg::in_payload_t         in_payload,
  // results out
  output logic                          out_valid,
  input  logic                          out_stall,
  output cdbt_pkg::out_payload_t        out_payload
);

  cdbt_pkg::state_t                state_r, state_nxt;
  logic [cdbt_pkg::THR_W-1:0]      thr_r;
  logic [cdbt_pkg::LIMIT_W-1:0]    limit_r;
  logic [VALUE_WIDTH-1:0]          x_r;
  logic [cdbt_pkg::LIMIT_W-1:0]    step_r;
  logic                            out_valid_r;
  cdbt_pkg::out_payload_t          out_payload_r;

  logic [VALUE_WIDTH-1:0]          thr_mask;
  logic [VALUE_WIDTH-1:0]          x_step;
  logic [127:0]                    start_full;
  cdbt_pkg::step_flags_t           flags;
  logic                            in_accept;
  logic                            out_free;
  logic                            done;
  logic                            advance;
  logic                            load_out;
  logic [1:0]                      done_status;

  assign start_full = {in_payload.start_high, in_payload.start_low};
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  // Thermometer mask of bits at or above the threshold
  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      thr_mask[i] = (8'(i) >= {1'b0, thr_r});
    end
  end

  cdbt_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .x        (x_r),
    .thr_mask (thr_mask),
    .x_nxt    (x_step),
    .flags    (flags)
  );

  // Termination checks, in the order the map applies them
  always_comb begin
    done        = 1'b1;
    done_status = cdbt_pkg::STATUS_LIMIT;
    if (step_r == limit_r) begin
      done_status = cdbt_pkg::STATUS_LIMIT;
    end else if (flags.below) begin
      done_status = cdbt_pkg::STATUS_BELOW;
    end else if (flags.odd && flags.ovf) begin
      done_status = cdbt_pkg::STATUS_OVERFLOW;
    end else begin
      done = 1'b0;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdbt_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = cdbt_pkg::ST_RUN;
      end
      cdbt_pkg::ST_RUN: begin
        if (done && out_free) state_nxt = cdbt_pkg::ST_IDLE;
      end
      default: state_nxt = cdbt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    advance  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      cdbt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      cdbt_pkg::ST_RUN: begin
        advance  = !done;
        load_out = done && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdbt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= cdbt_pkg::THR_RESET;
      limit_r     <= cdbt_pkg::LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          cdbt_pkg::CFG_THRESHOLD:  thr_r   <= cfg_wdata[cdbt_pkg::THR_W-1:0];
          cdbt_pkg::CFG_STEP_LIMIT: limit_r <= cfg_wdata[cdbt_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r    <= start_full[VALUE_WIDTH-1:0];
      step_r <= '0;
    end else if (advance) begin
      x_r    <= x_step;
      step_r <= step_r + 16'd1;
    end
    if (load_out) begin
      out_payload_r.status      <= done_status;
      out_payload_r.steps_taken <= step_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == cdbt_pkg::ST_RUN)
    else $error("accepted request did not start a run");

  a_step_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdbt_pkg::ST_RUN |-> step_r <= limit_r)
    else $error("step counter ran past the step limit");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_payload_r.status == cdbt_pkg::STATUS_BELOW ||
                     out_payload_r.status == cdbt_pkg::STATUS_LIMIT ||
                     out_payload_r.status == cdbt_pkg::STATUS_OVERFLOW))
    else $error("result carries an unused status code");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && done_status == cdbt_pkg::STATUS_LIMIT |-> step_r == limit_r)
    else $error("limit result with a short step count");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == cdbt_pkg::ST_RUN)
    else $error("result appeared without a run");
`endif

endmodule

// ----- tb/sv/collatz_descent_below_threshold_tb.sv -----
// Self-checking testbench for the accelerated Collatz descent checker.
`timescale 1ns / 100ps

module collatz_descent_below_threshold_tb;

  localparam int unsigned VALUE_WIDTH = 128;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  // longest item runs to the step limit (threshold 0, limit 65535); the limit covers three of them
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  localparam logic [127:0] ALL_ONES       = 128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF;
  // overflow bound for odd-step inputs: (2^128 - 2) / 3, rounded down
  localparam logic [127:0] OVERFLOW_GUARD = 128'h5555_5555_5555_5555_5555_5555_5555_5554;

  // short local names for the result codes used in the table
  localparam logic [1:0] RES_BELOW = cdbt_pkg::STATUS_BELOW;
  localparam logic [1:0] RES_LIMIT = cdbt_pkg::STATUS_LIMIT;
  localparam logic [1:0] RES_OVF   = cdbt_pkg::STATUS_OVERFLOW;

  typedef struct {
    logic [cdbt_pkg::THR_W-1:0]   thr;
    logic [cdbt_pkg::LIMIT_W-1:0] lim;
    logic [127:0]                 start;
    bit                           known;
    logic [1:0]                   status;
    logic [cdbt_pkg::LIMIT_W-1:0] steps;
  } directed_row_t;

  // Directed requests: rows with known set carry their result, the rest use the predictor
  directed_row_t directed_rows [22] = '{
    '{7'd71,  16'd5000,  128'd0,                                       1, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  128'h7F_FFFF_FFFF_FFFF_FFFF,                  1, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  128'd27,                                      1, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  128'h80_0000_0000_0000_0000,                  0, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  ALL_ONES,                                     1, RES_OVF,   16'd0},
    '{7'd71,  16'd5000,  OVERFLOW_GUARD + 128'd1,                      1, RES_OVF,   16'd0},
    '{7'd71,  16'd5000,  OVERFLOW_GUARD - 128'd1,                      0, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA, 0, RES_BELOW, 16'd0},
    '{7'd71,  16'd5000,  128'h7FFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1, RES_OVF,   16'd0},
    '{7'd71,  16'd1,     128'h100_0000_0000_0000_0000,                 0, RES_BELOW, 16'd0},
    '{7'd127, 16'd65535, 128'h7FFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1, RES_BELOW, 16'd0},
    '{7'd127, 16'd65535, 128'h8000_0000_0000_0000_0000_0000_0000_0000, 0, RES_BELOW, 16'd0},
    '{7'd127, 16'd65535, ALL_ONES,                                     1, RES_OVF,   16'd0},
    '{7'd0,   16'd0,     ALL_ONES,                                     1, RES_LIMIT, 16'd0},
    '{7'd0,   16'd0,     128'd0,                                       1, RES_LIMIT, 16'd0},
    '{7'd0,   16'd65535, 128'd0,                                       1, RES_BELOW, 16'd0},
    '{7'd0,   16'd65535, 128'd1,                                       1, RES_LIMIT, 16'd65535},
    '{7'd0,   16'd10,    128'd1,                                       1, RES_LIMIT, 16'd10},
    '{7'd1,   16'd65535, 128'd27,                                      0, RES_BELOW, 16'd0},
    '{7'd64,  16'd3,     128'hFFFF_FFFF_FFFF_FFFF,                     0, RES_BELOW, 16'd0},
    '{7'd64,  16'd3,     128'h1_0000_0000_0000_0000,                   0, RES_BELOW, 16'd0},
    '{7'd63,  16'd200,   128'h8000_0000_0000_0000,                     0, RES_BELOW, 16'd0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = cdbt_pkg::CFG_THRESHOLD;
  logic [cdbt_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  cdbt_pkg::in_payload_t        in_payload = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  cdbt_pkg::out_payload_t       out_payload;

  // configuration mirror
  logic [cdbt_pkg::THR_W-1:0]   thr_q = cdbt_pkg::THR_RESET;
  logic [cdbt_pkg::LIMIT_W-1:0] lim_q = cdbt_pkg::LIMIT_RESET;

  cdbt_pkg::out_payload_t       pending_descents [$];
  cdbt_pkg::out_payload_t       oldest_descent;
  int unsigned                  mismatch_count = 0;
  int unsigned                  quiet_cycles = 0;
  int unsigned                  burst_left = 0;
  bit                           hold_off_req = 1'b0;

  collatz_descent_below_threshold #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  always #5 clk = ~clk;

  // Predicted outcome of one descent run under the given settings
  function automatic cdbt_pkg::out_payload_t predict_descent(
      input logic [127:0] start,
      input logic [cdbt_pkg::THR_W-1:0] thr,
      input logic [cdbt_pkg::LIMIT_W-1:0] lim);
    logic [127:0] x;
    cdbt_pkg::out_payload_t res;
    int unsigned s;
    x = start;
    res.status = cdbt_pkg::STATUS_LIMIT;
    res.steps_taken = lim;
    for (s = 0; s < lim; s++) begin
      if ((x >> thr) == '0) begin
        res.status = cdbt_pkg::STATUS_BELOW;
        res.steps_taken = s[cdbt_pkg::LIMIT_W-1:0];
        return res;
      end
      if (!x[0]) begin
        x = x >> 1;
      end else if (x > OVERFLOW_GUARD) begin
        res.status = cdbt_pkg::STATUS_OVERFLOW;
        res.steps_taken = s[cdbt_pkg::LIMIT_W-1:0];
        return res;
      end else begin
        // (3x+1)/2 for odd x
        x = x + (x >> 1) + 128'd1;
      end
    end
    return res;
  endfunction

  // Start values: mostly bounded widths, plus full width, guard, threshold and tiny values
  function automatic logic [127:0] random_start(input logic [cdbt_pkg::THR_W-1:0] thr);
    logic [127:0] x;
    int unsigned w;
    x = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      2, 3, 4, 5: begin
        w = $urandom_range(1, 128);
        x = x >> (128 - w);
        x[w-1] = 1'b1;
      end
      6: x = OVERFLOW_GUARD - 128'd8 + 128'($urandom_range(0, 16));
      7: x = (128'd1 << thr) - 128'd4 + 128'($urandom_range(0, 8));
      8: x = 128'($urandom_range(0, 1000));
      9: x = ALL_ONES - 128'($urandom_range(0, 64));
      default: ;
    endcase
    return x;
  endfunction

  // Offer one request in bursts with random gaps; record its result at acceptance
  task automatic send_start(input logic [127:0] start, input cdbt_pkg::out_payload_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_payload <= cdbt_pkg::in_payload_t'(start);
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_descents = {pending_descents, want};
  endtask

  // Stop offering and wait until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_descents.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; upper threshold bits carry junk
  task automatic write_config(input logic [cdbt_pkg::THR_W-1:0] thr,
                              input logic [cdbt_pkg::LIMIT_W-1:0] lim);
    logic [cdbt_pkg::CFG_W-1:0] junk;
    junk = cdbt_pkg::CFG_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= cdbt_pkg::CFG_THRESHOLD;
    cfg_wdata <= {junk[cdbt_pkg::CFG_W-1:cdbt_pkg::THR_W], thr};
    @(posedge clk);
    cfg_index <= cdbt_pkg::CFG_STEP_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q = thr;
    lim_q = lim;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_descents.size() == 0) begin
        $error("unexpected result: status %0d steps_taken %0d",
               out_payload.status, out_payload.steps_taken);
        mismatch_count++;
      end else begin
        oldest_descent = pending_descents.pop_front();
        if (out_payload.status !== oldest_descent.status) begin
          $error("status: expected %0d, got %0d", oldest_descent.status, out_payload.status);
          mismatch_count++;
        end
        if (out_payload.steps_taken !== oldest_descent.steps_taken) begin
          $error("steps_taken: expected %0d, got %0d",
                 oldest_descent.steps_taken, out_payload.steps_taken);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: stall rate is redrawn after each random span; one long hold-off on request
  initial begin : receiver
    int unsigned pct;
    int unsigned span_left;
    pct = 0;
    span_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (span_left == 0) begin
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 90;
          endcase
          span_left = $urandom_range(20, 80);
        end
        span_left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [127:0]                 start;
    cdbt_pkg::out_payload_t       want;
    logic [cdbt_pkg::THR_W-1:0]   thr;
    logic [cdbt_pkg::LIMIT_W-1:0] lim;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].thr != thr_q || directed_rows[r].lim != lim_q) begin
        drain_results();
        write_config(directed_rows[r].thr, directed_rows[r].lim);
      end
      start = directed_rows[r].start;
      if (directed_rows[r].known) begin
        want.status      = directed_rows[r].status;
        want.steps_taken = directed_rows[r].steps;
      end else begin
        want = predict_descent(start, thr_q, lim_q);
      end
      send_start(start, want);
    end

    // random phases, each under its own settings
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin thr = cdbt_pkg::THR_RESET; lim = cdbt_pkg::LIMIT_RESET; end
        1: begin thr = 7'd127;    lim = 16'd65535;   end
        2: begin thr = 7'd0;      lim = 16'($urandom_range(1, 300)); end
        3: begin thr = 7'd1;      lim = 16'd65535;   end
        default: begin
          thr = 7'($urandom_range(1, 127));
          lim = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
                                            : 16'($urandom_range(200, 5000));
        end
      endcase
      drain_results();
      write_config(thr, lim);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        // receiver holds off while small values keep the block full
        if (p == 0 && i == 10) hold_off_req = 1'b1;
        if (p == 5 && i == 75) drain_results();
        start = hold_off_req ? 128'($urandom_range(0, 1000)) : random_start(thr_q);
        send_start(start, predict_descent(start, thr_q, lim_q));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_descents.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cdbt_pkg.sv
rtl/cdbt_step.sv
rtl/collatz_descent_below_threshold.sv
tb/sv/collatz_descent_below_threshold_tb.sv
